[design/palette_window_subset_search_defines.svh]
// ----------------------------------------------------------------------------
// Palette window subset search - assertion macros
// Shared concurrent assertion forms used by the top-level design file.
// ----------------------------------------------------------------------------
`ifndef PALETTE_WINDOW_SUBSET_SEARCH_DEFINES_SVH
`define PALETTE_WINDOW_SUBSET_SEARCH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PWSS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define PWSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/pwss_pkg.sv]
// ----------------------------------------------------------------------------
// Palette window subset search package
// Shared types and constants for the search block.
// ----------------------------------------------------------------------------
package pwss_pkg;

   localparam int COLOR_W     = 24;
   localparam int MAX_QUERY   = 16;
   localparam int QLEN_W      = 5;
   localparam int INDEX_W     = 32;
   localparam int WBITS_W     = 3;

   localparam int DEF_SEARCH_SPAN   = 1024 * 16;
   localparam int DEF_HISTORY_DEPTH = 32768;
   localparam int DEF_SHORT_FORWARD = 16;

   localparam logic [COLOR_W-1:0] COLOR_MASK_RESET = 24'hFFFFFF;

   // Action codes of an input transaction.
   localparam logic ACT_APPEND = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   typedef logic [COLOR_W-1:0] color_type;
   typedef color_type [MAX_QUERY-1:0] query_set_type;

   typedef struct packed {
      logic      action;
      color_type color;
      logic      last;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] match_index;
      logic [WBITS_W-1:0] window_bits;
   } rsp_type;

endpackage

[design/pwss_match_lanes.sv]
// ----------------------------------------------------------------------------
// Palette window subset search - match lanes
// Compares one history color against every stored query color under a mask.
// ----------------------------------------------------------------------------
module pwss_match_lanes (
   input  pwss_pkg::color_type                   hist_color,
   input  pwss_pkg::color_type                   mask,
   input  pwss_pkg::query_set_type               query_colors,
   input  logic [pwss_pkg::QLEN_W-1:0]           query_length,
   output logic [pwss_pkg::MAX_QUERY-1:0]        lane_match,
   output logic [pwss_pkg::MAX_QUERY-1:0]        lane_used
);
   import pwss_pkg::*;

   always_comb begin
      for (int k = 0; k < MAX_QUERY; k++) begin
         lane_used[k]  = (QLEN_W'(k) < query_length);
         lane_match[k] = lane_used[k] &&
                         ((hist_color & mask) == (query_colors[k] & mask));
      end
   end

endmodule

[design/palette_window_subset_search.sv]
// ----------------------------------------------------------------------------
// Palette window subset search - top level
// Color history with a sequenced window search for query sub-palettes.
// ----------------------------------------------------------------------------
// How the block is used:
// A transaction on the request side is taken at a rising edge with start
// high and busy low. An append transaction writes its color into the
// history memory in that cycle and busy stays low, so appends can come
// back to back. Query transactions that are not marked last are stored in
// the query register set; elements past sixteen are dropped. The query
// element marked last raises busy and starts the search. The search reads
// one history entry at a time through the single read port of the history
// memory (address cycle, then compare cycle in which all sixteen match
// lanes look at the entry). A single-color query reads at most SHORT_FORWARD
// entries. A longer query reads up to window-size entries for each of up
// to SEARCH_SPAN window end positions, and a five to eight color query
// that misses with eight-entry windows repeats with sixteen. How long
// the search runs thus depends on the data. When the search
// ends, the result transaction appears on rsp_item with rsp_valid high for
// exactly one cycle and busy drops. The receiver cannot stall the block.
// Reset clears the history count, the write address, the query length and
// the mask register (to all ones); history contents are left as they are.
// The mask register is written from csr_wr_data whenever csr_wr_en is high.
// ----------------------------------------------------------------------------
module palette_window_subset_search #(
   parameter int SEARCH_SPAN   = pwss_pkg::DEF_SEARCH_SPAN,
   parameter int HISTORY_DEPTH = pwss_pkg::DEF_HISTORY_DEPTH,
   parameter int SHORT_FORWARD = pwss_pkg::DEF_SHORT_FORWARD
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  pwss_pkg::req_type   req_item,
   output logic                rsp_valid,
   output pwss_pkg::rsp_type   rsp_item,
   input  logic                csr_wr_en,
   input  pwss_pkg::color_type csr_wr_data
);
   import pwss_pkg::*;

   `include "palette_window_subset_search_defines.svh"

   localparam int AW   = $clog2(HISTORY_DEPTH);
   localparam int MAXW = (SHORT_FORWARD > MAX_QUERY) ? SHORT_FORWARD : MAX_QUERY;
   localparam int JW   = $clog2(MAXW);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_CMP   = 2'd3;

   // History memory; written by appends, read by the search.
   color_type            hist_mem [HISTORY_DEPTH];
   color_type            rd_data_ff;

   logic [1:0]           state_ff, state_in;
   color_type            mask_ff, mask_in;
   logic [INDEX_W-1:0]   count_ff, count_in;
   logic [AW-1:0]        wr_addr_ff, wr_addr_in;
   query_set_type        query_ff, query_in;
   logic [QLEN_W-1:0]    qlen_ff, qlen_in;

   // Search registers.
   logic                 single_ff, single_in;
   logic [WBITS_W-1:0]   wbits_ff, wbits_in;
   logic [INDEX_W-1:0]   end_ff, end_in;
   logic [AW-1:0]        end_addr_ff, end_addr_in;
   logic [INDEX_W-1:0]   lowest_ff, lowest_in;
   logic [INDEX_W-1:0]   cur_ff, cur_in;
   logic [AW-1:0]        cur_addr_ff, cur_addr_in;
   logic [JW-1:0]        step_ff, step_in;
   logic [MAX_QUERY-1:0] hit_ff, hit_in;
   logic [INDEX_W-1:0]   best_ff, best_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 accept;
   logic                 do_append;
   logic [MAX_QUERY-1:0] lane_match, lane_used, hit_new;
   logic                 fresh, window_done, all_hit;
   logic [3:0]           wmask;
   logic [AW-1:0]        newest_addr;
   color_type            lane_mask;

   assign accept    = start && !busy;
   assign do_append = accept && (req_item.action == ACT_APPEND);
   assign lane_mask = single_ff ? COLOR_MASK_RESET : mask_ff;

   pwss_match_lanes u_lanes (
      .hist_color   (rd_data_ff),
      .mask         (lane_mask),
      .query_colors (query_ff),
      .query_length (single_ff ? QLEN_W'(1) : qlen_ff),
      .lane_match   (lane_match),
      .lane_used    (lane_used)
   );

   always_ff @(posedge clock) begin
      if (do_append) begin
         hist_mem[wr_addr_ff] <= req_item.color;
      end
      rd_data_ff <= hist_mem[cur_addr_ff];
   end

   always_comb begin
      newest_addr = (wr_addr_ff == '0) ? AW'(HISTORY_DEPTH - 1) : wr_addr_ff - AW'(1);
      wmask       = (4'd1 << wbits_ff) - 4'd1;
      hit_new     = hit_ff | lane_match;
      fresh       = |(lane_match & ~hit_ff);
      all_hit     = &(hit_new | ~lane_used);
      if (single_ff) begin
         window_done = (step_ff == JW'(SHORT_FORWARD - 1)) || (cur_ff == '0);
      end else begin
         window_done = (step_ff == JW'(wmask)) || (cur_ff == '0);
      end
   end

   always_comb begin
      state_in     = state_ff;
      mask_in      = csr_wr_en ? csr_wr_data : mask_ff;
      count_in     = count_ff;
      wr_addr_in   = wr_addr_ff;
      query_in     = query_ff;
      qlen_in      = qlen_ff;
      single_in    = single_ff;
      wbits_in     = wbits_ff;
      end_in       = end_ff;
      end_addr_in  = end_addr_ff;
      lowest_in    = lowest_ff;
      cur_in       = cur_ff;
      cur_addr_in  = cur_addr_ff;
      step_in      = step_ff;
      hit_in       = hit_ff;
      best_in      = best_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (do_append) begin
               count_in   = count_ff + INDEX_W'(1);
               wr_addr_in = (wr_addr_ff == AW'(HISTORY_DEPTH - 1)) ? '0
                            : wr_addr_ff + AW'(1);
            end else if (accept) begin
               if (qlen_ff < QLEN_W'(MAX_QUERY)) begin
                  query_in[qlen_ff[QLEN_W-2:0]] = req_item.color;
                  qlen_in = qlen_ff + QLEN_W'(1);
               end
               if (req_item.last) begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            single_in = (qlen_ff == QLEN_W'(1));
            if (qlen_ff <= QLEN_W'(1)) begin
               wbits_in = 3'd0;
            end else if (qlen_ff == QLEN_W'(2)) begin
               wbits_in = 3'd1;
            end else if (qlen_ff <= QLEN_W'(4)) begin
               wbits_in = 3'd2;
            end else if (qlen_ff <= QLEN_W'(8)) begin
               wbits_in = 3'd3;
            end else begin
               wbits_in = 3'd4;
            end
            lowest_in   = (count_ff >= INDEX_W'(SEARCH_SPAN))
                          ? count_ff - INDEX_W'(SEARCH_SPAN) : '0;
            end_in      = count_ff - INDEX_W'(1);
            end_addr_in = newest_addr;
            cur_in      = count_ff - INDEX_W'(1);
            cur_addr_in = newest_addr;
            step_in     = '0;
            hit_in      = '0;
            if (count_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               qlen_in      = '0;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            state_in = ST_READ;
            hit_in   = hit_new;
            if (fresh) begin
               best_in = cur_ff;
            end
            if (single_ff) begin
               // Newest exact match wins; stop at the first hit.
               if (lane_match[0]) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{found: 1'b1, match_index: cur_ff, window_bits: 3'd0};
                  qlen_in      = '0;
                  state_in     = ST_IDLE;
               end else if (window_done) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  qlen_in      = '0;
                  state_in     = ST_IDLE;
               end else begin
                  cur_in      = cur_ff - INDEX_W'(1);
                  cur_addr_in = (cur_addr_ff == '0) ? AW'(HISTORY_DEPTH - 1)
                                : cur_addr_ff - AW'(1);
                  step_in     = step_ff + JW'(1);
               end
            end else if (!window_done) begin
               cur_in      = cur_ff - INDEX_W'(1);
               cur_addr_in = (cur_addr_ff == '0) ? AW'(HISTORY_DEPTH - 1)
                             : cur_addr_ff - AW'(1);
               step_in     = step_ff + JW'(1);
            end else if (all_hit) begin
               // The last fresh hit while walking down is the lowest index.
               rsp_valid_in = 1'b1;
               rsp_in       = '{found: 1'b1, match_index: (fresh ? cur_ff : best_ff),
                                window_bits: wbits_ff};
               qlen_in      = '0;
               state_in     = ST_IDLE;
            end else if (end_ff != lowest_ff) begin
               end_in      = end_ff - INDEX_W'(1);
               end_addr_in = (end_addr_ff == '0) ? AW'(HISTORY_DEPTH - 1)
                             : end_addr_ff - AW'(1);
               cur_in      = end_ff - INDEX_W'(1);
               cur_addr_in = (end_addr_ff == '0) ? AW'(HISTORY_DEPTH - 1)
                             : end_addr_ff - AW'(1);
               step_in     = '0;
               hit_in      = '0;
            end else if (wbits_ff == 3'd3) begin
               // Eight-entry windows missed: retry the span with sixteen.
               wbits_in    = 3'd4;
               end_in      = count_ff - INDEX_W'(1);
               end_addr_in = newest_addr;
               cur_in      = count_ff - INDEX_W'(1);
               cur_addr_in = newest_addr;
               step_in     = '0;
               hit_in      = '0;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               qlen_in      = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mask_ff      <= COLOR_MASK_RESET;
         count_ff     <= '0;
         wr_addr_ff   <= '0;
         qlen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         count_ff     <= count_in;
         wr_addr_ff   <= wr_addr_in;
         qlen_ff      <= qlen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff    <= query_in;
      single_ff   <= single_in;
      wbits_ff    <= wbits_in;
      end_ff      <= end_in;
      end_addr_ff <= end_addr_in;
      lowest_ff   <= lowest_in;
      cur_ff      <= cur_in;
      cur_addr_ff <= cur_addr_in;
      step_ff     <= step_in;
      hit_ff      <= hit_in;
      best_ff     <= best_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // A result only follows a cycle in which the search was running.
   `PWSS_ASSERT_IMPL(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy), "result without search")
   // A miss carries a zero index and zero window bits.
   `PWSS_ASSERT_IMPL(a_miss_zero, clock, reset, rsp_valid && !rsp_item.found, (rsp_item.match_index == '0) && (rsp_item.window_bits == '0), "miss payload not zero")
   // The search starts only after the final query element was taken.
   `PWSS_ASSERT_IMPL(a_busy_cause, clock, reset, $rose(busy), $past(start) && $past(req_item.action) && $past(req_item.last), "search without final query element")
   // Each result leaves the query length cleared.
   `PWSS_ASSERT_NEXT(a_qlen_clear, clock, reset, rsp_valid_in, qlen_ff == '0, "query length not cleared")

endmodule
